// ----- hdl/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg
// Types and constants shared by the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;

endpackage

// ----- hdl/skvt_ram.sv -----
// ----------------------------------------------------------------------------
// skvt_ram
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module skvt_ram (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [skvt_pkg::AW-1:0] i_waddr,
    input  skvt_pkg::t_entry    i_wdata,
    input  logic [skvt_pkg::AW-1:0] i_raddr,
    output skvt_pkg::t_entry    o_rdata
);
    import skvt_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/sorted_key_value_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Ordered key/value table held in one memory; scan, then shift to insert/remove.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// request | in  | i_start / o_busy   | i_req  (action, key, value)
// result  | out | o_done (one cycle) | o_rsp  (status, out_key, out_value)
//
// A request scans slots in order, one memory read per cycle, until a key not
// less than the request key; a shift then moves one entry per cycle. Busy time is
// bounded by the single read port; o_done follows in the next cycle, when a new
// request may already start. Synchronous reset empties the table; no clearing
// pass. Result is shown one cycle with o_done and cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  skvt_pkg::t_req   i_req,
    output logic             o_busy,
    output logic             o_done,
    output skvt_pkg::t_rsp   o_rsp
);
    import skvt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CHECK = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    t_req        r_req, n_req;
    t_rsp        r_rsp, n_rsp;
    logic        r_done, n_done;
    t_entry      r_hold, n_hold;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    t_entry      wdata, rdata;
    logic        less;

    skvt_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign less = rdata.key < r_req.key;

    // r_idx: slot whose data arrives on rdata this cycle (scan) or next write slot
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_req   = r_req;
        n_rsp   = r_rsp;
        n_done  = 1'b0;
        n_hold  = r_hold;
        we      = 1'b0;
        waddr   = r_idx[AW-1:0];
        wdata   = r_hold;
        raddr   = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (i_start) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_state = (r_count == '0) ? S_CHECK : S_SCAN;
                end
            end
            S_SCAN: begin
                // rdata holds slot r_idx
                raddr = (r_idx + 1'b1 < CW'(CAPACITY)) ? AW'(r_idx + 1'b1) : '0;
                if (!less) begin
                    n_state = S_CHECK;
                    n_hold  = rdata;
                end else if (r_idx + 1'b1 >= r_count) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CHECK: begin
                n_rsp.out_key   = r_req.key;
                n_rsp.out_value = '0;
                if (r_idx < r_count && r_hold.key == r_req.key) begin
                    if (r_req.action == ACT_INSERT) begin
                        n_rsp.status    = ST_DUPLICATE;
                        n_rsp.out_value = r_hold.value;
                        n_state = S_DONE;
                    end else begin
                        n_rsp.status    = ST_REMOVED;
                        n_rsp.out_value = r_hold.value;
                        n_count = r_count - 1'b1;
                        n_idx   = r_idx;
                        raddr   = AW'(r_idx + 1'b1);
                        n_state = (r_idx + 1'b1 >= r_count) ? S_DONE : S_SHIFT;
                    end
                end else if (r_req.action == ACT_REMOVE) begin
                    n_rsp.status = ST_NOTFOUND;
                    n_state = S_DONE;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_rsp.status = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    // insert: write new pair, carry displaced entry upward
                    n_rsp.status = ST_INSERTED;
                    we      = 1'b1;
                    wdata   = '{key: r_req.key, value: r_req.value};
                    n_count = r_count + 1'b1;
                    n_idx   = r_idx + 1'b1;
                    raddr   = AW'(r_idx + 1'b1);
                    n_state = (r_idx >= r_count) ? S_DONE : S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (r_req.action == ACT_INSERT) begin
                    // write carried entry at r_idx, rdata holds old slot r_idx
                    we     = 1'b1;
                    wdata  = r_hold;
                    n_hold = rdata;
                    raddr  = AW'(r_idx + 1'b1);
                    n_idx  = r_idx + 1'b1;
                    if (r_idx + 1'b1 >= r_count) begin
                        n_state = S_DONE;
                    end
                end else begin
                    // rdata holds slot r_idx+1, move it down
                    we     = 1'b1;
                    wdata  = rdata;
                    raddr  = AW'(r_idx + 2'd2);
                    n_idx  = r_idx + 1'b1;
                    if (r_idx + 1'b1 >= r_count) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_idx  <= n_idx;
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_hold <= n_hold;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("entry count over capacity");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result while busy");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> $past(r_count) == r_count || $past(i_start))
        else $error("count changed while idle");
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.status == ST_INSERTED |-> r_count != '0)
        else $error("insert left table empty");
`endif
endmodule
